/* rtl/efx_pkg.sv */
package efx_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] SUM_INVERT = 8'hFF;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef struct packed {
		logic       open;
		logic       data_vld;
		logic [7:0] data;
		logic       close;
		logic [7:0] csum;
	} cmd_t;

	function automatic logic needs_esc(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

/* rtl/efx_front.sv */
module efx_front
	import efx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       empty_frame,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic       in_frame_q;
	logic [7:0] sum_q;
	logic [7:0] base_sum;
	logic [7:0] new_sum;
	logic       in_frame_d;
	logic [7:0] sum_d;

	always_comb begin
		base_sum     = in_frame_q ? sum_q : 8'h00;
		new_sum      = base_sum + data_byte;
		cmd.open     = !in_frame_q;
		cmd.data     = data_byte;
		if (empty_frame) begin
			cmd.data_vld = 1'b0;
			cmd.close    = 1'b1;
			cmd.csum     = base_sum ^ SUM_INVERT;
			in_frame_d   = 1'b0;
			sum_d        = 8'h00;
		end else begin
			cmd.data_vld = 1'b1;
			cmd.close    = last_byte;
			cmd.csum     = new_sum ^ SUM_INVERT;
			in_frame_d   = !last_byte;
			sum_d        = last_byte ? 8'h00 : new_sum;
		end
	end

	assign cmd_push = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			sum_q      <= 8'h00;
		end else if (cmd_push) begin
			in_frame_q <= in_frame_d;
			sum_q      <= sum_d;
		end
	end

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> sum_q == 8'h00)
		else $error("Running sum is not zero while no frame is open.");

endmodule

/* rtl/efx_cmd_fifo.sv */
module efx_cmd_fifo
	import efx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic rd_vld,
	output cmd_t rd_cmd
);

	cmd_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;

	assign full   = count_q == FIFO_CW'(FIFO_DEPTH);
	assign rd_vld = count_q != '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("Command queue count exceeds its depth.");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_vld)
		else $error("Command queue read while empty.");

endmodule

/* rtl/efx_back.sv */
module efx_back
	import efx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_vld,
	input  cmd_t       head_cmd,
	output logic       head_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_done
);

	localparam int M_OPEN = 0;
	localparam int M_DESC = 1;
	localparam int M_DATA = 2;
	localparam int M_CESC = 3;
	localparam int M_CSUM = 4;
	localparam int M_FLAG = 5;
	localparam int MASK_W = 6;

	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] head_mask;
	logic [MASK_W-1:0] cur_mask;
	logic [MASK_W-1:0] pick;
	logic [MASK_W-1:0] rest;
	cmd_t              cmd_q;
	cmd_t              cur_cmd;
	logic              from_head;
	logic              slot_free;
	logic              advance;
	logic              out_vld_q;
	logic [7:0]        byte_d;
	logic              done_d;
	logic [7:0]        line_byte_q;
	logic              run_last_q;
	logic              frame_done_q;

	always_comb begin
		head_mask         = '0;
		head_mask[M_OPEN] = head_cmd.open;
		head_mask[M_DESC] = head_cmd.data_vld && needs_esc(head_cmd.data);
		head_mask[M_DATA] = head_cmd.data_vld;
		head_mask[M_CESC] = head_cmd.close && needs_esc(head_cmd.csum);
		head_mask[M_CSUM] = head_cmd.close;
		head_mask[M_FLAG] = head_cmd.close;

		from_head = (mask_q == '0) && head_vld;
		cur_cmd   = from_head ? head_cmd : cmd_q;
		cur_mask  = from_head ? head_mask : mask_q;
		slot_free = !out_vld_q || pop;
		advance   = slot_free && (cur_mask != '0);
		pick      = cur_mask & (~cur_mask + MASK_W'(1));
		rest      = cur_mask & ~pick;

		done_d = 1'b0;
		priority if (pick[M_OPEN]) begin
			byte_d = FLAG_BYTE;
		end else if (pick[M_DESC]) begin
			byte_d = ESC_BYTE;
		end else if (pick[M_DATA]) begin
			byte_d = needs_esc(cur_cmd.data) ? (cur_cmd.data ^ ESC_XOR) : cur_cmd.data;
		end else if (pick[M_CESC]) begin
			byte_d = ESC_BYTE;
		end else if (pick[M_CSUM]) begin
			byte_d = needs_esc(cur_cmd.csum) ? (cur_cmd.csum ^ ESC_XOR) : cur_cmd.csum;
		end else begin
			byte_d = FLAG_BYTE;
			done_d = 1'b1;
		end
	end

	assign head_pop   = advance && from_head;
	assign empty      = !out_vld_q;
	assign line_byte  = line_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				mask_q <= rest;
			end
			if (slot_free) begin
				out_vld_q <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q        <= cur_cmd;
			line_byte_q  <= byte_d;
			run_last_q   <= rest == '0;
			frame_done_q <= done_d;
		end
	end

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && frame_done_q |-> run_last_q)
		else $error("Closing flag beat is not the last beat of its item.");

	a_desc_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[M_DESC] |-> mask_q[M_DATA])
		else $error("Pending escape without its payload byte.");

	a_cesc_has_csum: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[M_CESC] |-> mask_q[M_CSUM] && mask_q[M_FLAG])
		else $error("Pending checksum escape without checksum and flag.");

endmodule

/* rtl/escaped_frame_transmitter.sv */
// Channel   Handshake      Beat fields
// input     push / full    data_byte, last_byte, empty_frame
// output    pop / empty    line_byte, run_last, frame_done
//
// Each input beat yields one to six output beats, one per cycle unless pop stalls.
// A plain payload byte takes one output beat, an escaped one two; a four-entry command
// queue lets input run ahead of the line while the output register waits for pop.
// Reset clears the frame state, the queue and the output valid flag; no startup pass.
// full rises only when the command queue holds four items.
module escaped_frame_transmitter
	import efx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       empty_frame,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_done
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic cmd_push;
	logic head_vld;
	logic head_pop;

	efx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.empty_frame (empty_frame),
		.cmd_push    (cmd_push),
		.cmd         (front_cmd)
	);

	efx_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (front_cmd),
		.full   (full),
		.rd_en  (head_pop),
		.rd_vld (head_vld),
		.rd_cmd (head_cmd)
	);

	efx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_vld   (head_vld),
		.head_cmd   (head_cmd),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

endmodule

/* tb/sv/frame_scoreboard_pkg.sv */
package frame_scoreboard_pkg;

	import efx_pkg::*;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_done;
	} line_beat_t;

	// Tracks the open frame and its payload sum, and queues the line beats that each
	// accepted payload beat must produce.
	class frame_scoreboard;
		bit         frame_open;
		bit [7:0]   payload_sum;
		line_beat_t line_q[$];
		int         error_count;

		function new();
			frame_open  = 1'b0;
			payload_sum = 8'h00;
			error_count = 0;
		endfunction

		function void add_line(input logic [7:0] b, input logic done);
			line_beat_t beat;
			beat.line_byte  = b;
			beat.run_last   = 1'b0;
			beat.frame_done = done;
			line_q.push_back(beat);
		endfunction

		function void add_stuffed(input logic [7:0] b);
			if (b == FLAG_BYTE || b == ESC_BYTE) begin
				add_line(ESC_BYTE, 1'b0);
				add_line(b ^ ESC_XOR, 1'b0);
			end else begin
				add_line(b, 1'b0);
			end
		endfunction

		function void close_frame();
			add_stuffed(payload_sum ^ SUM_INVERT);
			add_line(FLAG_BYTE, 1'b1);
			frame_open  = 1'b0;
			payload_sum = 8'h00;
		endfunction

		function void note_payload(input logic [7:0] data, input logic last,
				input logic empty_req);
			if (empty_req) begin
				if (!frame_open) begin
					payload_sum = 8'h00;
					add_line(FLAG_BYTE, 1'b0);
				end
				close_frame();
			end else begin
				if (!frame_open) begin
					payload_sum = 8'h00;
					frame_open  = 1'b1;
					add_line(FLAG_BYTE, 1'b0);
				end
				add_stuffed(data);
				payload_sum = payload_sum + data;
				if (last) begin
					close_frame();
				end
			end
			line_q[line_q.size() - 1].run_last = 1'b1;
		endfunction

		function void check_line_beat(input logic [7:0] line_byte, input logic run_last,
				input logic frame_done);
			line_beat_t want;
			if (line_q.size() == 0) begin
				$error("unexpected beat: line_byte %h run_last %b frame_done %b",
					line_byte, run_last, frame_done);
				error_count++;
				return;
			end
			want = line_q.pop_front();
			if (line_byte !== want.line_byte) begin
				$error("line_byte: expected %h, got %h", want.line_byte, line_byte);
				error_count++;
			end
			if (run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, run_last);
				error_count++;
			end
			if (frame_done !== want.frame_done) begin
				$error("frame_done: expected %b, got %b", want.frame_done, frame_done);
				error_count++;
			end
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
module tb_top;

	import efx_pkg::*;
	import frame_scoreboard_pkg::*;

	localparam int ITEM_TARGET  = 430;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 24;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic       full;
	logic [7:0] data_byte   = 8'h00;
	logic       last_byte   = 1'b0;
	logic       empty_frame = 1'b0;
	logic       empty;
	logic       pop         = 1'b0;
	logic [7:0] line_byte;
	logic       run_last;
	logic       frame_done;

	frame_scoreboard sb = new();

	int items_sent = 0;
	bit send_burst = 1'b0;
	bit pop_burst  = 1'b0;

	escaped_frame_transmitter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.empty_frame (empty_frame),
		.empty       (empty),
		.pop         (pop),
		.line_byte   (line_byte),
		.run_last    (run_last),
		.frame_done  (frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			sb.note_payload(data_byte, last_byte, empty_frame);
		end
		if (arst_n && pop && !empty) begin
			sb.check_line_beat(line_byte, run_last, frame_done);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		do begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end while (idle_cycles < IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				pop_burst = !pop_burst;
			end
			gap = pop_burst ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return FLAG_BYTE ^ ESC_XOR;
			3: return ESC_BYTE ^ ESC_XOR;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic [7:0] d, input logic l, input logic e);
		int gap;
		if ($urandom_range(0, 31) == 0) begin
			send_burst = !send_burst;
		end
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		data_byte   <= d;
		last_byte   <= l;
		empty_frame <= e;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++) begin
			send_item(pick_byte(), i == len - 1, 1'b0);
		end
	endtask

	task automatic run_directed();
		send_item(8'hA5, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(FLAG_BYTE, 1'b0, 1'b0);
		send_item(ESC_BYTE, 1'b0, 1'b0);
		send_item(FLAG_BYTE ^ ESC_XOR, 1'b0, 1'b0);
		send_item(ESC_BYTE ^ ESC_XOR, 1'b1, 1'b0);
		// The checksum itself falls on the flag and escape values here.
		send_item(8'h81, 1'b1, 1'b0);
		send_item(8'h82, 1'b1, 1'b0);
		send_item(FLAG_BYTE, 1'b0, 1'b0);
		send_item(8'h03, 1'b1, 1'b0);
		// An empty request closes a frame that is still open.
		send_item(8'h12, 1'b0, 1'b0);
		send_item(8'h34, 1'b1, 1'b1);
		send_item(ESC_BYTE, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h5A, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic run_random();
		int kind;
		int len;
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 78) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				send_frame(len);
			end else if (kind < 88) begin
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					send_item(pick_byte(), 1'b0, 1'b0);
				end
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		push <= 1'b0;
		while (sb.line_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.line_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
